// File: rtl/afdp_pkg.sv
`default_nettype none
package afdp_pkg;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int MAG_W   = 24;
  localparam int VALUE_W = 25;

  localparam logic [2:0] INT_DIGITS_MAX  = 3'd4;
  localparam logic [1:0] FRAC_DIGITS_MAX = 2'd3;

  // Parse state of the current value field.
  typedef struct packed {
    logic             in_field;
    logic             is_negative;
    logic             dot_seen;
    logic [2:0]       int_cnt;
    logic [1:0]       frac_cnt;
    logic             field_bad;
    logic [MAG_W-1:0] mag;
  } field_t;

  // What one character produces on the result side.
  typedef struct packed {
    logic                      emit;
    logic                      ok;
    logic signed [VALUE_W-1:0] value;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/ascii_fixed_decimal_parser.sv
`default_nettype none
// Channel  | Direction | Ports
// ---------+-----------+-----------------------------------------------
// in       | input     | in_valid, in_ready, in_rx_byte[7:0]
// out      | output    | out_valid, out_ready, out_value_milli[24:0],
//          |           | out_value_ok
//
// One character is taken per cycle; its state update and any result are
// formed in the same cycle and the result is held in the output register.
// A result appears in the cycle after the '!' (or over-long character) that
// causes it. The input stalls only while a held result is not being taken.
// Reset (rst_n low, synchronous) clears the parse state, the frame length
// and the output valid flag.
module ascii_fixed_decimal_parser #(
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [24:0] out_value_milli,
  output logic             out_value_ok
);
  import afdp_pkg::*;

  localparam int FLW = $clog2(MAX_FRAME) + 1;

  field_t                    field_r, field_nxt;
  result_t                   step_res;
  logic [FLW-1:0]            frame_len_r, frame_len_nxt;
  logic [FLW-1:0]            frame_len_inc;
  logic                      frame_full;
  logic                      in_accept;
  logic                      out_valid_r;
  logic                      value_ok_r;
  logic signed [VALUE_W-1:0] value_r;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_accept     = in_valid && in_ready;
  assign frame_len_inc = frame_len_r + FLW'(1);
  assign frame_full    = frame_len_inc >= FLW'(MAX_FRAME);
  assign frame_len_nxt = step_res.emit ? '0 : frame_len_inc;

  afdp_step u_step (
    .rx_byte    (in_rx_byte),
    .frame_full (frame_full),
    .cur        (field_r),
    .nxt        (field_nxt),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r     <= '0;
      frame_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        field_r     <= field_nxt;
        frame_len_r <= frame_len_nxt;
        out_valid_r <= step_res.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step_res.emit) begin
      value_r    <= step_res.value;
      value_ok_r <= step_res.ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_milli = value_r;
  assign out_value_ok    = value_ok_r;

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_len_r < FLW'(MAX_FRAME))
    else $error("frame length reached the limit without a result");

  a_bang_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_rx_byte == CH_BANG) |=>
      out_valid && (frame_len_r == '0) && !field_r.in_field)
    else $error("terminator did not give a result and clear the state");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_ok |-> out_value_milli == '0)
    else $error("invalid result carries a non-zero value");

  a_digit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (field_r.int_cnt <= INT_DIGITS_MAX) && (field_r.frac_cnt <= FRAC_DIGITS_MAX))
    else $error("digit count out of range");

  a_dot_needs_int: assert property (@(posedge clk) disable iff (!rst_n)
    field_r.dot_seen |-> (field_r.int_cnt != 3'd0) && field_r.in_field)
    else $error("dot recorded without an integer digit");

endmodule
`default_nettype wire

// File: rtl/afdp_step.sv
`default_nettype none
module afdp_step (
  input  wire logic [7:0]       rx_byte,
  input  wire logic             frame_full,
  input  wire afdp_pkg::field_t cur,
  output afdp_pkg::field_t      nxt,
  output afdp_pkg::result_t     res
);
  import afdp_pkg::*;

  logic [3:0]       digit_diff;
  logic [MAG_W-1:0] mag_times_ten;
  logic             field_ok;

  assign digit_diff    = rx_byte[3:0] - CH_ZERO[3:0];
  assign mag_times_ten = (cur.mag << 3) + (cur.mag << 1) + MAG_W'(digit_diff);
  assign field_ok      = cur.in_field && !cur.field_bad && (cur.int_cnt != 3'd0) &&
                         cur.dot_seen && (cur.frac_cnt == FRAC_DIGITS_MAX);

  always_comb begin
    nxt       = cur;
    res.emit  = 1'b0;
    res.ok    = 1'b0;
    res.value = '0;
    if (rx_byte == CH_BANG) begin
      res.emit = 1'b1;
      res.ok   = field_ok;
      if (field_ok) begin
        res.value = cur.is_negative ? -$signed({1'b0, cur.mag}) : $signed({1'b0, cur.mag});
      end
      nxt = '0;
    end else if (frame_full) begin
      // The frame has run to its limit without a terminator.
      res.emit = 1'b1;
      nxt      = '0;
    end else if (rx_byte == CH_EQ) begin
      nxt          = '0;
      nxt.in_field = 1'b1;
    end else if (cur.in_field && !cur.field_bad) begin
      case (rx_byte) inside
        [CH_ZERO:CH_NINE]: begin
          if (!cur.dot_seen) begin
            if (cur.int_cnt >= INT_DIGITS_MAX) begin
              nxt.field_bad = 1'b1;
            end else begin
              nxt.int_cnt = cur.int_cnt + 3'd1;
              nxt.mag     = mag_times_ten;
            end
          end else begin
            if (cur.frac_cnt >= FRAC_DIGITS_MAX) begin
              nxt.field_bad = 1'b1;
            end else begin
              nxt.frac_cnt = cur.frac_cnt + 2'd1;
              nxt.mag      = mag_times_ten;
            end
          end
        end
        CH_DOT: begin
          if (cur.dot_seen || (cur.int_cnt == 3'd0)) begin
            nxt.field_bad = 1'b1;
          end else begin
            nxt.dot_seen = 1'b1;
          end
        end
        CH_MINUS: begin
          if (!cur.is_negative && !cur.dot_seen && (cur.int_cnt == 3'd0)) begin
            nxt.is_negative = 1'b1;
          end else begin
            nxt.field_bad = 1'b1;
          end
        end
        default: begin
          nxt.field_bad = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/ascii_fixed_decimal_parser_tb.sv
`default_nettype none
module ascii_fixed_decimal_parser_tb;
  import afdp_pkg::*;

  localparam int FRAME_LIMIT  = 256;
  localparam int RANDOM_CHARS = 450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic             in_field;
    logic             negative;
    logic             dot_seen;
    logic [2:0]       int_digits;
    logic [1:0]       frac_digits;
    logic             bad;
    logic [MAG_W-1:0] mag;
  } field_track_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      ok;
  } reading_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_mode_e;
  typedef enum {FRAME_GOOD, FRAME_BROKEN, FRAME_NOISE, FRAME_RESTARTED} frame_kind_e;
  typedef enum {CORRUPT_REPLACE, CORRUPT_INSERT, CORRUPT_DROP, CORRUPT_COUNTS} corrupt_e;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      out_ready  = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value_milli;
  logic                      out_value_ok;

  logic [7:0]   tx_chars[$];
  logic [7:0]   field_buf[$];
  reading_t     expected_values[$];
  field_track_t field_st;
  int           frame_len;

  int errors        = 0;
  int chars_sent    = 0;
  int results_seen  = 0;
  int results_good  = 0;
  int results_long  = 0;

  string directed_frames[] = '{
    "=1234.567!", "=9999.999!", "=-9999.999!", "=0.000!", "=-0.000!", "=-0.001!",
    "ab=12.5!", "x=1=2.000!", "-=5.000!", "=1-2.000!", "=--1.000!", "=5.-000!",
    "=12345.000!", "=1.2345!", "=1..000!", "=.123!", "=1x.000!", "!", "=12!",
    "=5.000=!", "="
  };

  ascii_fixed_decimal_parser #(
    .MAX_FRAME(FRAME_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_milli(out_value_milli),
    .out_value_ok   (out_value_ok)
  );

  always #10 clk = ~clk;

  // Predicts the result, if any, of one accepted character.
  function void parse_char(input logic [7:0] c);
    reading_t                  r;
    logic signed [VALUE_W-1:0] mag_s;
    frame_len = frame_len + 1;
    if (c == CH_BANG) begin
      r.ok = field_st.in_field && !field_st.bad && field_st.int_digits != 3'd0 &&
             field_st.dot_seen && field_st.frac_digits == FRAC_DIGITS_MAX;
      mag_s = VALUE_W'(field_st.mag);
      r.value = !r.ok ? '0 : (field_st.negative ? -mag_s : mag_s);
      expected_values.push_back(r);
      field_st = '0;
      frame_len = 0;
    end else if (frame_len >= FRAME_LIMIT) begin
      r.ok = 1'b0;
      r.value = '0;
      expected_values.push_back(r);
      results_long++;
      field_st = '0;
      frame_len = 0;
    end else if (c == CH_EQ) begin
      field_st = '0;
      field_st.in_field = 1'b1;
    end else if (field_st.in_field && !field_st.bad) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!field_st.dot_seen && field_st.int_digits >= INT_DIGITS_MAX) begin
          field_st.bad = 1'b1;
        end else if (field_st.dot_seen && field_st.frac_digits >= FRAC_DIGITS_MAX) begin
          field_st.bad = 1'b1;
        end else begin
          if (field_st.dot_seen) begin
            field_st.frac_digits = field_st.frac_digits + 2'd1;
          end else begin
            field_st.int_digits = field_st.int_digits + 3'd1;
          end
          field_st.mag = field_st.mag * 24'd10 + MAG_W'(c - CH_ZERO);
        end
      end else if (c == CH_DOT) begin
        if (field_st.dot_seen || field_st.int_digits == 3'd0) begin
          field_st.bad = 1'b1;
        end else begin
          field_st.dot_seen = 1'b1;
        end
      end else if (c == CH_MINUS) begin
        if (!field_st.negative && !field_st.dot_seen && field_st.int_digits == 3'd0) begin
          field_st.negative = 1'b1;
        end else begin
          field_st.bad = 1'b1;
        end
      end else begin
        field_st.bad = 1'b1;
      end
    end
  endfunction

  task report_mismatch(input string what, input logic signed [VALUE_W-1:0] got,
                       input logic signed [VALUE_W-1:0] want);
    $display("MISMATCH on result %0d: %s, got %0d, expected %0d",
             results_seen, what, got, want);
    errors++;
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      tx_chars.push_back(s[i]);
    end
  endtask

  // Filler bytes of any value except the terminator.
  task add_junk(input int n);
    logic [7:0] b;
    repeat (n) begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (b == CH_BANG);
      tx_chars.push_back(b);
    end
  endtask

  task fill_field(input bit neg, input int n_int, input int n_frac);
    field_buf.delete();
    field_buf.push_back(CH_EQ);
    if (neg) begin
      field_buf.push_back(CH_MINUS);
    end
    repeat (n_int) field_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    field_buf.push_back(CH_DOT);
    repeat (n_frac) field_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task send_field();
    foreach (field_buf[i]) begin
      tx_chars.push_back(field_buf[i]);
    end
    tx_chars.push_back(CH_BANG);
  endtask

  // Sender: bursts of random length separated by random gaps; some gaps are empty.
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tx_chars.size() != 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= tx_chars.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns at random.
  ready_mode_e ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= ~out_ready;
      endcase
    end
  end

  // Checks each result against the oldest prediction, then predicts the input side.
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      field_st  = '0;
      frame_len = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          report_mismatch("result with nothing expected", out_value_milli, 'x);
        end else begin
          want = expected_values.pop_front();
          if (want.ok) results_good++;
          if (out_value_ok !== want.ok) begin
            report_mismatch("value_ok", VALUE_W'(out_value_ok), VALUE_W'(want.ok));
          end
          if (out_value_milli !== want.value) begin
            report_mismatch("value_milli", out_value_milli, want.value);
          end
        end
      end
      if (in_valid && in_ready) begin
        chars_sent++;
        parse_char(in_rx_byte);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          start;
    int          r;
    frame_kind_e kind;
    corrupt_e    how;
    int          pos;

    foreach (directed_frames[i]) add_text(directed_frames[i]);
    // Bytes with the top bit set or all zero: ignored before '=', fatal inside a field.
    tx_chars.push_back(8'h00);
    tx_chars.push_back(8'hFF);
    add_text("=3.141!=3.1");
    tx_chars.push_back(8'h80);
    add_text("41!");
    // A frame that reaches the length limit exactly on its terminator is still good.
    add_junk(FRAME_LIMIT - 10);
    add_text("=1234.567!");
    // One byte too many: the last one is eaten, and the '!' after it starts afresh.
    add_junk(FRAME_LIMIT - 6);
    add_text("=1.000!=5.000!");

    add_junk($urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 30));
    fill_field(1'b0, 2, 3);
    send_field();

    start = tx_chars.size();
    while (tx_chars.size() - start < RANDOM_CHARS) begin
      r = $urandom_range(0, 9);
      kind = (r < 6) ? FRAME_GOOD : (r < 8) ? FRAME_BROKEN : (r < 9) ? FRAME_NOISE
                                                                      : FRAME_RESTARTED;
      case (kind)
        FRAME_GOOD: begin
          add_junk($urandom_range(0, 3));
          fill_field(1'($urandom_range(0, 1)), $urandom_range(1, 4), 3);
          send_field();
        end
        FRAME_BROKEN: begin
          how = corrupt_e'($urandom_range(0, 3));
          if (how == CORRUPT_COUNTS) begin
            if ($urandom_range(0, 1) == 1) begin
              fill_field(1'($urandom_range(0, 1)), 5 * $urandom_range(0, 1), 3);
            end else begin
              fill_field(1'($urandom_range(0, 1)), $urandom_range(1, 4),
                         ($urandom_range(0, 1) == 1) ? 4 : $urandom_range(0, 2));
            end
          end else begin
            fill_field(1'($urandom_range(0, 1)), $urandom_range(1, 4), 3);
            pos = $urandom_range(0, field_buf.size() - 1);
            case (how)
              CORRUPT_REPLACE: field_buf[pos] = 8'($urandom_range(0, 255));
              CORRUPT_INSERT:  field_buf.insert(pos, 8'($urandom_range(0, 255)));
              default:         field_buf.delete(pos);
            endcase
          end
          send_field();
        end
        FRAME_NOISE: begin
          repeat ($urandom_range(1, 8)) tx_chars.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          add_text("=");
          add_junk($urandom_range(0, 4));
          fill_field(1'($urandom_range(0, 1)), $urandom_range(1, 4), 3);
          send_field();
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (tx_chars.size() != 0 || in_valid);
    while (expected_values.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d characters into %0d results: %0d well formed, %0d cut by the length limit.",
             chars_sent, results_seen, results_good, results_long);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
